// ===== sv/cte_pkg.sv =====
// Shared types, constants and head-building functions for the CBOR text string encoder.
// No dependencies; the core, the emitter and the top level refer to this package by scoped names.
package cte_pkg;

    // Item action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    // CBOR major type 3 and fixed bytes
    localparam logic [2:0] MAJOR_TEXT  = 3'd3;
    localparam logic [4:0] AI_ONE_BYTE = 5'd24;
    localparam logic [4:0] AI_TWO_BYTE = 5'd25;
    localparam logic [4:0] AI_FOUR_BYTE = 5'd26;
    localparam logic [7:0] HEAD_INDEF  = 8'h7F;
    localparam logic [7:0] BREAK_BYTE  = 8'hFF;

    // Longest head, and room for the longest run of bytes from one item
    localparam int HEAD_MAX = 5;
    localparam int RUN_MAX  = 7;

    typedef struct packed {
        logic [HEAD_MAX-1:0][7:0] bytes;  // index 0 goes out first
        logic [2:0]               count;
    } cte_head_t;

    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;   // index 0 goes out first
        logic [2:0]              count;
        logic                    done;    // last byte closes the string
    } cte_run_t;

    // Build a definite-length head for a text string of len bytes
    function automatic cte_head_t head_of(logic [31:0] len);
        cte_head_t h;
        h.bytes = '0;
        if (len < 32'd24) begin
            h.bytes[0] = {MAJOR_TEXT, len[4:0]};
            h.count    = 3'd1;
        end
        else if (len < 32'h100) begin
            h.bytes[0] = {MAJOR_TEXT, AI_ONE_BYTE};
            h.bytes[1] = len[7:0];
            h.count    = 3'd2;
        end
        else if (len < 32'h10000) begin
            h.bytes[0] = {MAJOR_TEXT, AI_TWO_BYTE};
            h.bytes[1] = len[15:8];
            h.bytes[2] = len[7:0];
            h.count    = 3'd3;
        end
        else begin
            h.bytes[0] = {MAJOR_TEXT, AI_FOUR_BYTE};
            h.bytes[1] = len[31:24];
            h.bytes[2] = len[23:16];
            h.bytes[3] = len[15:8];
            h.bytes[4] = len[7:0];
            h.count    = 3'd5;
        end
        return h;
    endfunction

    // Size of the next chunk: all that remains, capped by a nonzero segment size
    function automatic logic [31:0] chunk_of(logic [31:0] seg, logic [31:0] left);
        logic [31:0] c;
        c = left;
        if (seg != 32'd0 && seg < left) begin
            c = seg;
        end
        return c;
    endfunction

endpackage

// ===== sv/cte_channels.sv =====
// Valid/ready channel interfaces for the CBOR text string encoder: items, results, config.
// Depends on nothing.
interface cte_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] string_length;
    logic [7:0]  data_byte;

    modport source (output valid, output action, output string_length, output data_byte,
                    input ready);
    modport sink   (input valid, input action, input string_length, input data_byte,
                    output ready);
endinterface

interface cte_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       string_done;

    modport source (output valid, output out_byte, output last_of_run, output string_done,
                    input ready);
    modport sink   (input valid, input out_byte, input last_of_run, input string_done,
                    output ready);
endinterface

interface cte_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] segment_size;

    modport source (output valid, output segment_size, input ready);
    modport sink   (input valid, input segment_size, output ready);
endinterface

// ===== sv/cbor_text_string_encoder_unit.sv =====
// Top level of the CBOR text string encoder (major type 3, definite or chunked).
// Depends on cte_pkg, cte_channels.sv, cte_core and cte_emit.
//
//   channel  direction  payload                                   beat
//   item     in         action, string_length, data_byte          one item
//   result   out        out_byte, last_of_run, string_done        one encoded byte
//   cfg      in         segment_size                              one register write
//
// An item waits in the input register until the run buffer is free, then its run of
// 1 to 6 bytes leaves the run buffer at one byte per cycle while result is ready;
// the serializer sets the rate, so data items that cause one byte go through at one
// per cycle. An item that causes no byte leaves the input register once the run
// buffer is free. cfg is always ready. Reset clears all string state and the segment
// size. A stalled result holds the buffer; the input register then holds one more
// item before item.ready drops.
module cbor_text_string_encoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    cte_in_if.sink     item,
    cte_out_if.source  result,
    cte_cfg_if.sink    cfg
);

    cte_pkg::cte_run_t run;
    logic              run_valid;
    logic              run_ready;

    cte_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (cfg),
        .run       (run),
        .run_valid (run_valid),
        .run_ready (run_ready)
    );

    cte_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .run       (run),
        .run_valid (run_valid),
        .run_ready (run_ready),
        .result    (result)
    );

endmodule

// ===== sv/cte_core.sv =====
// Input register, string state and head logic: turns one item into a run of up to 6 bytes.
// Depends on cte_pkg and the channel interfaces in cte_channels.sv.
module cte_core (
    input  logic               clk,
    input  logic               rst_n,
    cte_in_if.sink             item,
    cte_cfg_if.sink            cfg,
    output cte_pkg::cte_run_t  run,
    output logic               run_valid,
    input  logic               run_ready
);

    logic        item_valid_reg;
    logic        item_valid_next;
    logic        action_reg;
    logic [31:0] length_reg;
    logic [7:0]  data_reg;

    logic [31:0] segment_size_reg;
    logic [31:0] bytes_left_reg;
    logic [31:0] bytes_left_next;
    logic [31:0] chunk_left_reg;
    logic [31:0] chunk_left_next;
    logic        open_reg;
    logic        open_next;
    logic        indef_reg;
    logic        indef_next;

    logic        accept;
    logic        advance;
    logic [31:0] bytes_dec;
    logic [31:0] chunk_dec;
    logic [31:0] chunk_size;
    cte_pkg::cte_head_t head;
    cte_pkg::cte_run_t  run_next;

    // Hand an item on whenever the run buffer can take its bytes
    assign advance    = item_valid_reg && run_ready;
    assign item.ready = !item_valid_reg || advance;
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    assign item_valid_next = accept ? 1'b1 : (advance ? 1'b0 : item_valid_reg);

    // Hold the accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= item.action;
            length_reg <= item.string_length;
            data_reg   <= item.data_byte;
        end
    end

    // Take configuration beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segment_size_reg <= '0;
        end
        else if (cfg.valid)
        begin
            segment_size_reg <= cfg.segment_size;
        end
    end

    assign bytes_dec = bytes_left_reg - 32'd1;
    assign chunk_dec = chunk_left_reg - 32'd1;

    // Pick the length that a head must carry, if any
    always_comb
    begin
        if (action_reg == cte_pkg::ACT_START)
        begin
            chunk_size = (segment_size_reg != 32'd0)
                       ? cte_pkg::chunk_of(segment_size_reg, length_reg) : length_reg;
        end
        else
        begin
            chunk_size = cte_pkg::chunk_of(segment_size_reg, bytes_dec);
        end
        head = cte_pkg::head_of(chunk_size);
    end

    // Build the run and the next string state
    always_comb
    begin
        run_next        = '0;
        bytes_left_next = bytes_left_reg;
        chunk_left_next = chunk_left_reg;
        open_next       = open_reg;
        indef_next      = indef_reg;

        if (action_reg == cte_pkg::ACT_START)
        begin
            bytes_left_next = length_reg;
            if (segment_size_reg != 32'd0)
            begin
                indef_next        = 1'b1;
                run_next.bytes[0] = cte_pkg::HEAD_INDEF;
                if (length_reg == 32'd0)
                begin
                    run_next.bytes[1] = cte_pkg::BREAK_BYTE;
                    run_next.count    = 3'd2;
                    run_next.done     = 1'b1;
                    open_next         = 1'b0;
                    chunk_left_next   = '0;
                end
                else
                begin
                    for (int i = 0; i < cte_pkg::HEAD_MAX; i++)
                    begin
                        run_next.bytes[i+1] = head.bytes[i];
                    end
                    run_next.count  = head.count + 3'd1;
                    open_next       = 1'b1;
                    chunk_left_next = chunk_size;
                end
            end
            else
            begin
                indef_next = 1'b0;
                for (int i = 0; i < cte_pkg::HEAD_MAX; i++)
                begin
                    run_next.bytes[i] = head.bytes[i];
                end
                run_next.count  = head.count;
                run_next.done   = (length_reg == 32'd0);
                open_next       = (length_reg != 32'd0);
                chunk_left_next = length_reg;
            end
        end
        else if (open_reg)
        begin
            // Pass the data byte, then close the string, open the next chunk or go on in this one
            run_next.bytes[0] = data_reg;
            run_next.count    = 3'd1;
            bytes_left_next   = bytes_dec;
            if (bytes_dec == 32'd0)
            begin
                if (indef_reg)
                begin
                    run_next.bytes[1] = cte_pkg::BREAK_BYTE;
                    run_next.count    = 3'd2;
                end
                run_next.done   = 1'b1;
                open_next       = 1'b0;
                chunk_left_next = '0;
            end
            else if (chunk_dec == 32'd0)
            begin
                for (int i = 0; i < cte_pkg::HEAD_MAX; i++)
                begin
                    run_next.bytes[i+1] = head.bytes[i];
                end
                run_next.count  = head.count + 3'd1;
                chunk_left_next = chunk_size;
            end
            else
            begin
                chunk_left_next = chunk_dec;
            end
        end
    end

    // Commit string state as the item moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            chunk_left_reg <= '0;
            open_reg       <= 1'b0;
            indef_reg      <= 1'b0;
        end
        else if (advance)
        begin
            bytes_left_reg <= bytes_left_next;
            chunk_left_reg <= chunk_left_next;
            open_reg       <= open_next;
            indef_reg      <= indef_next;
        end
    end

    // Drop items that cause no bytes
    assign run       = run_next;
    assign run_valid = advance && (run_next.count != 3'd0);

endmodule

// ===== sv/cte_emit.sv =====
// Run buffer and byte serializer: sends one byte of the current run per result beat.
// Depends on cte_pkg and the channel interfaces in cte_channels.sv.
module cte_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  cte_pkg::cte_run_t  run,
    input  logic               run_valid,
    output logic               run_ready,
    cte_out_if.source          result
);

    cte_pkg::cte_run_t run_reg;
    logic              busy_reg;
    logic              busy_next;
    logic [2:0]        index_reg;
    logic [2:0]        index_next;
    logic              last_byte;
    logic              beat;

    assign last_byte = (index_reg == run_reg.count - 3'd1);
    assign beat      = result.valid && result.ready;
    assign run_ready = !busy_reg || (beat && last_byte);

    // Drive the current byte
    assign result.valid       = busy_reg;
    assign result.out_byte    = run_reg.bytes[index_reg];
    assign result.last_of_run = last_byte;
    assign result.string_done = last_byte && run_reg.done;

    // Load a new run or advance through the current one
    always_comb
    begin
        busy_next  = busy_reg;
        index_next = index_reg;
        if (run_valid)
        begin
            busy_next  = 1'b1;
            index_next = '0;
        end
        else if (beat)
        begin
            if (last_byte)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                index_next = index_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            index_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            index_reg <= index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_valid)
        begin
            run_reg <= run;
        end
    end

endmodule
